### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
// Needs a clock named clk and a reset named rst in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PCRT_ASSERT_NOW(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

// next-cycle implication
`define PCRT_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

### rtl/core/pcrt_pkg.sv
// Shared types and constants of the point cloud rigid transform.
// No dependencies.
package pcrt_pkg;

  localparam int COORD_BITS     = 32;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_BITS      = COEF_FRAC_BITS + 2;
  localparam int ANG_BITS       = 17;
  localparam int CFG_BITS       = (COORD_BITS > ANG_BITS) ? COORD_BITS : ANG_BITS;
  localparam int N_REGS         = 6;
  localparam int REG_IDX_BITS   = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_PITCH   = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_ROLL    = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_YAW     = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_SHIFT_X = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_SHIFT_Y = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_SHIFT_Z = 3'd5;

  localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
  localparam logic [47:0] RAD_PER_UNIT = 48'(PI_Q60 / 64'd23040);
  localparam logic [63:0] RECIP_NUM    = 64'd1 << 32;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;
  typedef logic signed [ANG_BITS-1:0]   ang_t;

  typedef struct packed {
    logic start;
  } gen_ctl_t;

  typedef struct packed {
    logic busy;
  } gen_stat_t;

  // Taylor factorial steps: sin terms 0..4, cos terms 5..10
  function automatic logic [7:0] taylor_div(input logic [3:0] k);
    logic [7:0] d;
    case (k)
      4'd0:    d = 8'd6;
      4'd1:    d = 8'd20;
      4'd2:    d = 8'd42;
      4'd3:    d = 8'd72;
      4'd4:    d = 8'd110;
      4'd5:    d = 8'd2;
      4'd6:    d = 8'd12;
      4'd7:    d = 8'd30;
      4'd8:    d = 8'd56;
      4'd9:    d = 8'd90;
      4'd10:   d = 8'd132;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / step); the quotient estimate is low by at most one
  function automatic logic [31:0] taylor_recip(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd0:    r = 32'(RECIP_NUM / 64'd6);
      4'd1:    r = 32'(RECIP_NUM / 64'd20);
      4'd2:    r = 32'(RECIP_NUM / 64'd42);
      4'd3:    r = 32'(RECIP_NUM / 64'd72);
      4'd4:    r = 32'(RECIP_NUM / 64'd110);
      4'd5:    r = 32'(RECIP_NUM / 64'd2);
      4'd6:    r = 32'(RECIP_NUM / 64'd12);
      4'd7:    r = 32'(RECIP_NUM / 64'd30);
      4'd8:    r = 32'(RECIP_NUM / 64'd56);
      4'd9:    r = 32'(RECIP_NUM / 64'd90);
      4'd10:   r = 32'(RECIP_NUM / 64'd132);
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/pcrt_in_if.sv
// Input point channel: valid/ready plus point payload.
// Depends on pcrt_pkg.
interface pcrt_in_if;
  logic             valid;
  logic             ready;
  pcrt_pkg::coord_t in_x;
  pcrt_pkg::coord_t in_y;
  pcrt_pkg::coord_t in_z;
  logic             in_last;
  modport source (output valid, in_x, in_y, in_z, in_last, input ready);
  modport sink (input valid, in_x, in_y, in_z, in_last, output ready);
endinterface

### rtl/core/pcrt_out_if.sv
// Output point channel: valid/ready plus transformed point payload.
// Depends on pcrt_pkg.
interface pcrt_out_if;
  logic             valid;
  logic             ready;
  pcrt_pkg::coord_t out_x;
  pcrt_pkg::coord_t out_y;
  pcrt_pkg::coord_t out_z;
  logic             out_last;
  modport source (output valid, out_x, out_y, out_z, out_last, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_last, output ready);
endinterface

### rtl/core/pcrt_coef_gen.sv
// Rotation matrix builder: Taylor sin/cos sequencer and 3x3 product sequencer.
// Depends on pcrt_pkg.
module pcrt_coef_gen (
  input  logic                clk,
  input  logic                rst,
  input  pcrt_pkg::ang_t      pitch,
  input  pcrt_pkg::ang_t      roll,
  input  pcrt_pkg::ang_t      yaw,
  input  pcrt_pkg::gen_ctl_t  ctl,
  output pcrt_pkg::gen_stat_t stat,
  output pcrt_pkg::coef_t     coef [9]
);
  import pcrt_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RED  = 4'd1;
  localparam logic [3:0] ST_T    = 4'd2;
  localparam logic [3:0] ST_T2   = 4'd3;
  localparam logic [3:0] ST_MUL  = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_ACC  = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_MAT  = 4'd8;
  localparam logic [3:0] ST_FIX  = 4'd9;

  localparam int SH = 30 - COEF_FRAC_BITS;
  localparam coef_t ONE = coef_t'(1) <<< COEF_FRAC_BITS;

  logic [3:0]  state;
  logic [1:0]  ang_sel;
  logic [12:0] u;
  logic [1:0]  quad;
  logic        swap;
  logic [29:0] t;
  logic [29:0] t2;
  logic [30:0] term;
  logic [31:0] sum;
  logic [31:0] sin_q;
  logic [3:0]  kk;
  logic [31:0] dvd;
  logic [31:0] quo;
  logic [3:0]  step;
  logic signed [COEF_BITS+COEF_BITS:0] acc;
  coef_t sx, cx, sy, cy, sz, cz, a10, a12, a20, a22;

  ang_t        ang;
  logic signed [17:0] am;
  logic [15:0] amu;
  logic [1:0]  q_new;
  logic [13:0] uq;
  logic [60:0] tprod;
  logic [30:0] ma;
  logic [29:0] mb;
  logic [60:0] mprod;
  logic [30:0] mq;
  logic [7:0]  dv;
  logic [31:0] recip;
  logic [63:0] qprod;
  logic [39:0] dprod;
  logic [31:0] rest;
  logic        sub;
  logic [31:0] sum_new;
  coef_t       s_r, c_r, so, co, s_f, c_f;
  coef_t       opa, opb;
  logic signed [COEF_BITS+COEF_BITS-1:0] prod;
  logic signed [COEF_BITS+COEF_BITS:0]   psum, pmag;
  coef_t       rnd;
  logic        first;

  always_comb begin
    case (ang_sel)
      2'd0:    ang = pitch;
      2'd1:    ang = roll;
      default: ang = yaw;
    endcase
    am = 18'(ang);
    if (am < 0) am = am + 18'sd46080;
    if (am < 0) am = am + 18'sd46080;
    if (am >= 18'sd46080) am = am - 18'sd46080;
    amu = 16'(am);
    if (amu >= 16'd34560) begin
      q_new = 2'd3;
      uq = 14'(amu - 16'd34560);
    end else if (amu >= 16'd23040) begin
      q_new = 2'd2;
      uq = 14'(amu - 16'd23040);
    end else if (amu >= 16'd11520) begin
      q_new = 2'd1;
      uq = 14'(amu - 16'd11520);
    end else begin
      q_new = 2'd0;
      uq = 14'(amu);
    end

    tprod = 61'(u) * 61'(RAD_PER_UNIT);
    ma = (state == ST_T2) ? {1'b0, t} : term;
    mb = (state == ST_T2) ? t : t2;
    mprod = 61'(ma) * 61'(mb);
    mq = 31'((mprod + (61'd1 << 29)) >> 30);
    dv = taylor_div(kk);
    recip = taylor_recip(kk);
    qprod = 64'(dvd) * 64'(recip);
    dprod = 40'(quo) * 40'(dv);
    rest = dvd - 32'(dprod);

    sub = (kk <= 4'd4) ? ~kk[0] : kk[0];
    sum_new = sub ? sum - quo : sum + quo;

    s_r = coef_t'((sin_q + (32'd1 << (SH - 1))) >> SH);
    c_r = coef_t'((sum + (32'd1 << (SH - 1))) >> SH);
    so = swap ? c_r : s_r;
    co = swap ? s_r : c_r;
    case (quad)
      2'd1: begin
        s_f = co;
        c_f = -so;
      end
      2'd2: begin
        s_f = -so;
        c_f = -co;
      end
      2'd3: begin
        s_f = -co;
        c_f = so;
      end
      default: begin
        s_f = so;
        c_f = co;
      end
    endcase

    case (step)
      4'd0:    begin opa = sx;  opb = sy;  end
      4'd1:    begin opa = sx;  opb = cy;  end
      4'd2:    begin opa = cx;  opb = sy;  end
      4'd3:    begin opa = cx;  opb = cy;  end
      4'd4:    begin opa = cy;  opb = cz;  end
      4'd5:    begin opa = '0;  opb = -sz; end
      4'd6:    begin opa = cy;  opb = sz;  end
      4'd7:    begin opa = '0;  opb = cz;  end
      4'd8:    begin opa = a10; opb = cz;  end
      4'd9:    begin opa = cx;  opb = -sz; end
      4'd10:   begin opa = a10; opb = sz;  end
      4'd11:   begin opa = cx;  opb = cz;  end
      4'd12:   begin opa = a20; opb = cz;  end
      4'd13:   begin opa = -sx; opb = -sz; end
      4'd14:   begin opa = a20; opb = sz;  end
      default: begin opa = -sx; opb = cz;  end
    endcase
    prod = opa * opb;
    first = (step < 4'd4) || !step[0];
    psum = (first ? '0 : acc) + (COEF_BITS+COEF_BITS+1)'(prod);
    pmag = (psum < 0) ? -psum : psum;
    pmag = (pmag + ((COEF_BITS+COEF_BITS+1)'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    rnd = (psum < 0) ? -coef_t'(pmag) : coef_t'(pmag);
  end

  assign stat.busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      ang_sel <= '0;
      kk      <= '0;
      step    <= '0;
      for (int i = 0; i < 9; i++) coef[i] <= (i % 4 == 0) ? ONE : '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (ctl.start) begin
            ang_sel <= '0;
            state   <= ST_RED;
          end
        end
        ST_RED: begin
          quad <= q_new;
          if (uq > 14'd5760) begin
            u    <= 13'(14'd11520 - uq);
            swap <= 1'b1;
          end else begin
            u    <= 13'(uq);
            swap <= 1'b0;
          end
          state <= ST_T;
        end
        ST_T: begin
          t     <= 30'((tprod + (61'd1 << 29)) >> 30);
          state <= ST_T2;
        end
        ST_T2: begin
          t2    <= mq[29:0];
          term  <= {1'b0, t};
          sum   <= {2'b0, t};
          kk    <= '0;
          state <= ST_MUL;
        end
        ST_MUL: begin
          dvd   <= 32'(mq) + 32'(dv >> 1);
          state <= ST_DIV;
        end
        ST_DIV: begin
          quo   <= 32'(qprod >> 32);
          state <= ST_FIX;
        end
        ST_FIX: begin
          if (rest >= 32'(dv)) quo <= quo + 32'd1;
          state <= ST_ACC;
        end
        ST_ACC: begin
          if (kk == 4'd4) begin
            sin_q <= sum_new;
            term  <= 31'd1 << 30;
            sum   <= 32'd1 << 30;
            kk    <= kk + 4'd1;
            state <= ST_MUL;
          end else if (kk == 4'd10) begin
            sum   <= sum_new;
            state <= ST_FIN;
          end else begin
            term  <= quo[30:0];
            sum   <= sum_new;
            kk    <= kk + 4'd1;
            state <= ST_MUL;
          end
        end
        ST_FIN: begin
          case (ang_sel)
            2'd0: begin
              sx <= s_f;
              cx <= c_f;
            end
            2'd1: begin
              sy <= s_f;
              cy <= c_f;
            end
            default: begin
              sz <= s_f;
              cz <= c_f;
            end
          endcase
          if (ang_sel == 2'd2) begin
            step  <= '0;
            state <= ST_MAT;
          end else begin
            ang_sel <= ang_sel + 2'd1;
            state   <= ST_RED;
          end
        end
        ST_MAT: begin
          acc  <= psum;
          step <= step + 4'd1;
          case (step)
            4'd0:  a10 <= rnd;
            4'd1:  a12 <= rnd;
            4'd2:  a20 <= rnd;
            4'd3:  a22 <= rnd;
            4'd5:  coef[0] <= rnd;
            4'd7:  coef[1] <= rnd;
            4'd9:  coef[3] <= rnd;
            4'd11: coef[4] <= rnd;
            4'd13: coef[6] <= rnd;
            4'd15: begin
              coef[7] <= rnd;
              coef[2] <= -sy;
              coef[5] <= a12;
              coef[8] <= a22;
              state   <= ST_IDLE;
            end
            default: ;
          endcase
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/point_cloud_rigid_transform.sv
// Point cloud rigid transform top level: config registers, coefficient
// pipeline and result register. Depends on pcrt_pkg, pcrt_in_if, pcrt_out_if,
// pcrt_coef_gen and assert_macros.svh.
//
// Usage: points enter on pts_in (valid/ready) and leave on pts_out, one result
// per point, in order. Each result is p*Rx(pitch)*Ry(roll)*Rz(yaw) + shift,
// rounded half away from zero and saturated to the coordinate range.
// The result passes through the input, product and result registers; throughput
// is one point per cycle while the receiver keeps up and no rebuild is running.
// Registers are written through cfg_we/cfg_index/cfg_data. Any write to one of
// the N_REGS registers marks the matrix stale; the rebuild then runs in
// pcrt_coef_gen, a shared-multiplier Taylor sequencer: per angle, 11 terms, each a
// multiply, reciprocal divide, fix-up and accumulate step, then 16 matrix steps;
// pts_in.ready comes back when the rebuild after the last write is done.
// Reset clears the angles and shifts and loads the identity matrix.
// A stalled receiver freezes the whole pipeline; ready follows the result
// register, so a point is still taken in the cycle its slot frees.
module point_cloud_rigid_transform (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [pcrt_pkg::REG_IDX_BITS-1:0]   cfg_index,
  input  logic [pcrt_pkg::CFG_BITS-1:0]       cfg_data,
  pcrt_in_if.sink                             pts_in,
  pcrt_out_if.source                          pts_out
);
  import pcrt_pkg::*;

  localparam int PW = COORD_BITS + COEF_BITS;
  localparam int SW = PW + 3;

  ang_t   pitch, roll, yaw;
  coord_t shift_x, shift_y, shift_z;
  logic   stale;
  coef_t  coef [9];
  gen_ctl_t  gctl;
  gen_stat_t gstat;

  logic   en, accept;
  logic   v1, v2, ov;
  coord_t p1 [3];
  logic   l1, l2, ol;
  logic signed [PW-1:0] pr [9];
  coord_t ores [3];
  coord_t sh [3];

  function automatic coord_t finish(input logic signed [SW-1:0] v);
    logic [SW-1:0] mag;
    logic [SW-1:0] r;
    logic [SW-1:0] lim;
    mag = (v < 0) ? SW'(-v) : SW'(v);
    r = (mag + (SW'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
    lim = (v < 0) ? (SW'(1) << (COORD_BITS - 1)) : ((SW'(1) << (COORD_BITS - 1)) - SW'(1));
    if (r > lim) r = lim;
    return (v < 0) ? coord_t'(-r) : coord_t'(r);
  endfunction

  pcrt_coef_gen u_gen (
    .clk   (clk),
    .rst   (rst),
    .pitch (pitch),
    .roll  (roll),
    .yaw   (yaw),
    .ctl   (gctl),
    .stat  (gstat),
    .coef  (coef)
  );

  assign gctl.start = stale && !gstat.busy;
  assign en = !ov || pts_out.ready;
  assign pts_in.ready = en && !stale && !gstat.busy;
  assign accept = pts_in.valid && pts_in.ready;
  assign sh[0] = shift_x;
  assign sh[1] = shift_y;
  assign sh[2] = shift_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch   <= '0;
      roll    <= '0;
      yaw     <= '0;
      shift_x <= '0;
      shift_y <= '0;
      shift_z <= '0;
      stale   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PITCH:   pitch   <= cfg_data[ANG_BITS-1:0];
          REG_ROLL:    roll    <= cfg_data[ANG_BITS-1:0];
          REG_YAW:     yaw     <= cfg_data[ANG_BITS-1:0];
          REG_SHIFT_X: shift_x <= cfg_data[COORD_BITS-1:0];
          REG_SHIFT_Y: shift_y <= cfg_data[COORD_BITS-1:0];
          REG_SHIFT_Z: shift_z <= cfg_data[COORD_BITS-1:0];
          default: ;
        endcase
      end
      if (cfg_we && (cfg_index < REG_IDX_BITS'(N_REGS))) stale <= 1'b1;
      else if (gctl.start) stale <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      ov <= 1'b0;
    end else if (en) begin
      v1 <= accept;
      v2 <= v1;
      ov <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (accept) begin
        p1[0] <= pts_in.in_x;
        p1[1] <= pts_in.in_y;
        p1[2] <= pts_in.in_z;
        l1    <= pts_in.in_last;
      end
      for (int i = 0; i < 9; i++) pr[i] <= PW'(p1[i / 3]) * PW'(coef[i]);
      l2 <= l1;
      for (int j = 0; j < 3; j++) begin
        ores[j] <= finish(SW'(pr[j]) + SW'(pr[3 + j]) + SW'(pr[6 + j])
                          + (SW'(sh[j]) <<< COEF_FRAC_BITS));
      end
      ol <= l2;
    end
  end

  assign pts_out.valid    = ov;
  assign pts_out.out_x    = ores[0];
  assign pts_out.out_y    = ores[1];
  assign pts_out.out_z    = ores[2];
  assign pts_out.out_last = ol;

`include "assert_macros.svh"
  `PCRT_ASSERT_NOW(a_no_accept_rebuild, accept, !stale && !gstat.busy)
  `PCRT_ASSERT_NEXT(a_start_busy, gctl.start, gstat.busy)
  `PCRT_ASSERT_NEXT(a_pipe_moves, v2 && en, ov)

endmodule

### tb/pcrt_tb_if.sv
// Testbench-side note: the block's channel interfaces (pcrt_in_if, pcrt_out_if)
// come with the RTL; this file holds the shared stimulus record type.
// Depends on pcrt_pkg.
package pcrt_tb_pkg;
  import pcrt_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } point_t;
endpackage

### tb/point_cloud_rigid_transform_tb.sv
// Testbench of point_cloud_rigid_transform: directed table then random points,
// under several angle/shift settings, checked against a fixed-point predictor.
// Depends on pcrt_pkg, pcrt_tb_pkg, pcrt_in_if, pcrt_out_if and the RTL.
module point_cloud_rigid_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pcrt_pkg::*;
  import pcrt_tb_pkg::*;

  localparam longint ONE = 64'sd1 <<< COEF_FRAC_BITS;
  localparam longint LIMIT = 1500000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [REG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;

  pcrt_in_if pts_in ();
  pcrt_out_if pts_out ();

  point_cloud_rigid_transform uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pts_in(pts_in), .pts_out(pts_out)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [CFG_BITS-1:0] regs [N_REGS];
  longint coeffs [9];
  logic stale;
  point_t expected_points [$];
  int mismatches = 0;
  longint cycles = 0;
  bit quiet = 1'b0;
  bit hold_long = 1'b0;

  function automatic longint rnd_shift(longint v, int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic void taylor_octant(longint u, output longint s, output longint c);
    longint t, t2, term, sum;
    longint rad;
    rad = 64'h3243F6A8885A308D / 23040;
    t = (u * rad + (64'sd1 <<< 29)) >>> 30;
    t2 = q30_mul(t, t);
    term = t;
    sum = t;
    for (int k = 1; k <= 5; k++) begin
      term = (q30_mul(term, t2) + (2*k)*(2*k+1)/2) / ((2*k)*(2*k+1));
      sum += (k % 2) ? -term : term;
    end
    s = sum;
    term = 64'sd1 <<< 30;
    sum = term;
    for (int k = 1; k <= 6; k++) begin
      term = (q30_mul(term, t2) + (2*k-1)*(2*k)/2) / ((2*k-1)*(2*k));
      sum += (k % 2) ? -term : term;
    end
    c = sum;
  endfunction

  function automatic void angle_sincos(logic [CFG_BITS-1:0] r, output longint s,
                                       output longint c);
    longint a, q, u, s0, c0, t;
    a = longint'(ang_t'(r[ANG_BITS-1:0])) % 46080;
    if (a < 0) a += 46080;
    q = a / 11520;
    u = a % 11520;
    if (u > 5760) taylor_octant(11520 - u, c0, s0);
    else taylor_octant(u, s0, c0);
    s0 = rnd_shift(s0, 30 - COEF_FRAC_BITS);
    c0 = rnd_shift(c0, 30 - COEF_FRAC_BITS);
    if (q == 1) begin
      t = s0; s0 = c0; c0 = -t;
    end else if (q == 2) begin
      s0 = -s0; c0 = -c0;
    end else if (q == 3) begin
      t = s0; s0 = -c0; c0 = t;
    end
    s = s0;
    c = c0;
  endfunction

  function automatic void mat3(input longint x[9], input longint y[9], output longint r[9]);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r[i*3+j] = rnd_shift(x[i*3]*y[j] + x[i*3+1]*y[3+j] + x[i*3+2]*y[6+j],
                             COEF_FRAC_BITS);
  endfunction

  function automatic void rebuild_rotation();
    longint s, c, rx[9], ry[9], rz[9], a[9];
    angle_sincos(regs[REG_PITCH], s, c);
    rx = '{ONE, 0, 0, 0, c, s, 0, -s, c};
    angle_sincos(regs[REG_ROLL], s, c);
    ry = '{c, 0, -s, 0, ONE, 0, s, 0, c};
    angle_sincos(regs[REG_YAW], s, c);
    rz = '{c, s, 0, -s, c, 0, 0, 0, ONE};
    mat3(rx, ry, a);
    mat3(a, rz, coeffs);
  endfunction

  function automatic coord_t round_sat(logic signed [127:0] v);
    logic signed [127:0] m;
    m = (v < 0) ? -v : v;
    m = (m + (128'sd1 <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    if (v < 0) return (m > (128'sd1 <<< (COORD_BITS-1))) ? coord_t'(1 <<< (COORD_BITS-1))
                                                          : coord_t'(-m);
    return (m > (128'sd1 <<< (COORD_BITS-1)) - 1) ? {1'b0, {(COORD_BITS-1){1'b1}}}
                                                  : coord_t'(m);
  endfunction

  function automatic point_t transform_point(point_t p);
    logic signed [127:0] acc;
    longint pv[3];
    point_t r;
    coord_t o[3];
    if (stale) begin
      rebuild_rotation();
      stale = 1'b0;
    end
    pv = '{longint'(p.x), longint'(p.y), longint'(p.z)};
    for (int j = 0; j < 3; j++) begin
      acc = 128'(longint'(coord_t'(regs[REG_SHIFT_X + j]))) * ONE;
      for (int i = 0; i < 3; i++) acc += 128'(pv[i]) * 128'(coeffs[i*3+j]);
      o[j] = round_sat(acc);
    end
    r.x = o[0];
    r.y = o[1];
    r.z = o[2];
    r.last = p.last;
    return r;
  endfunction

  task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    if (idx < N_REGS) begin
      regs[idx] = (idx < 3) ? CFG_BITS'(v[ANG_BITS-1:0]) : v;
      stale = 1'b1;
    end
  endtask

  task automatic writes_done();
    cfg_we <= 1'b0;
  endtask

  task automatic send_point(point_t p, bit idle_ok);
    int gap;
    if (idle_ok && !quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      pts_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pts_in.valid <= 1'b1;
    pts_in.in_x <= p.x;
    pts_in.in_y <= p.y;
    pts_in.in_z <= p.z;
    pts_in.in_last <= p.last;
    do @(posedge clk); while (!pts_in.ready);
    expected_points.push_back(transform_point(p));
  endtask

  task automatic drain();
    pts_in.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic coord_t rnd_coord();
    case ($urandom_range(0, 5))
      0: return coord_t'($urandom_range(0, 4000)) - 2000;
      1: return {1'b0, {(COORD_BITS-1){1'b1}}} - coord_t'($urandom_range(0, 3));
      2: return {1'b1, {(COORD_BITS-1){1'b0}}} + coord_t'($urandom_range(0, 3));
      default: return coord_t'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] rnd_angle();
    case ($urandom_range(0, 3))
      0: return CFG_BITS'(ang_t'(11520 * $urandom_range(0, 8) - 46080));
      1: return CFG_BITS'(ang_t'(-65536 + $urandom_range(0, 3)));
      default: return CFG_BITS'($urandom());
    endcase
  endfunction

  // receiver: random stalls, one long hold-off, always ready near the end
  initial begin
    int n;
    pts_out.ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        pts_out.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        pts_out.ready <= 1'b0;
        n = $urandom_range(1, 17);
        repeat (n - 1) @(posedge clk);
      end else begin
        pts_out.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    point_t e;
    if (!rst && pts_out.valid && pts_out.ready) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%0d", pts_out.out_x);
      end else begin
        e = expected_points.pop_front();
        if (e.x !== pts_out.out_x || e.y !== pts_out.out_y || e.z !== pts_out.out_z ||
            e.last !== pts_out.out_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0d %b got %0d %0d %0d %b", e.x, e.y, e.z,
                     e.last, pts_out.out_x, pts_out.out_y, pts_out.out_z,
                     pts_out.out_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  typedef struct {
    point_t p;
    bit     typed;
    point_t r;
  } row_t;

  row_t table_rows [] = '{
    '{'{32'sd0, 32'sd0, 32'sd0, 1'b0}, 1, '{32'sd0, 32'sd0, 32'sd0, 1'b0}},
    '{'{32'sd1, -32'sd1, 32'sd7, 1'b1}, 1, '{32'sd1, -32'sd1, 32'sd7, 1'b1}},
    '{'{CMAX, CMIN, CMAX, 1'b0}, 1, '{CMAX, CMIN, CMAX, 1'b0}},
    '{'{CMIN, CMAX, -32'sd1, 1'b1}, 1, '{CMIN, CMAX, -32'sd1, 1'b1}},
    '{'{32'h55555555, 32'hAAAAAAAA, 32'h0F0F0F0F, 1'b0}, 0, '{0, 0, 0, 1'b0}},
    '{'{32'hAAAAAAAA, 32'h55555555, 32'hF0F0F0F0, 1'b1}, 0, '{0, 0, 0, 1'b0}}
  };

  // typed results hold for the identity setting after reset only
  task automatic run_table(bit check_typed);
    foreach (table_rows[i]) begin
      send_point(table_rows[i].p, 1'b0);
      if (check_typed && table_rows[i].typed && expected_points[$] !== table_rows[i].r) begin
        mismatches++;
        if (mismatches <= 10) $display("table row %0d predictor disagrees", i);
      end
    end
  endtask

  task automatic random_points(int n);
    point_t p;
    repeat (n) begin
      p.x = rnd_coord();
      p.y = rnd_coord();
      p.z = rnd_coord();
      p.last = $urandom_range(0, 1);
      send_point(p, 1'b1);
    end
  endtask

  initial begin
    pts_in.valid = 1'b0;
    pts_in.in_x = '0;
    pts_in.in_y = '0;
    pts_in.in_z = '0;
    pts_in.in_last = 1'b0;
    foreach (regs[i]) regs[i] = '0;
    for (int i = 0; i < 9; i++) coeffs[i] = (i % 4 == 0) ? ONE : 0;
    stale = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity after reset
    run_table(1'b1);
    drain();

    // extremes: full-turn and quarter-turn angles, extreme shifts, plus an index past the list
    write_reg(REG_PITCH, CFG_BITS'(ang_t'(46080)));
    write_reg(REG_ROLL, CFG_BITS'(ang_t'(-46080)));
    write_reg(REG_YAW, CFG_BITS'(ang_t'(11520)));
    write_reg(REG_SHIFT_X, CMAX);
    write_reg(REG_SHIFT_Y, CMIN);
    write_reg(REG_SHIFT_Z, 0);
    write_reg(3'd7, '1);
    writes_done();
    run_table(1'b0);
    drain();

    // long receiver hold-off while points keep coming
    hold_long = 1'b1;
    random_points(20);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_PITCH, rnd_angle());
      write_reg(REG_ROLL, rnd_angle());
      write_reg(REG_YAW, rnd_angle());
      write_reg(REG_SHIFT_X, ph == 0 ? CMIN : coord_t'($urandom()));
      write_reg(REG_SHIFT_Y, ph == 0 ? CMAX : coord_t'($urandom_range(0, 100000)));
      write_reg(REG_SHIFT_Z, coord_t'($urandom()));
      if (ph == 3) write_reg(REG_SHIFT_Z, regs[REG_SHIFT_Z]);
      writes_done();
      if (ph == 5) quiet = 1'b1;
      random_points(85);
      drain();
    end

    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

### point_cloud_rigid_transform.f
+incdir+rtl/core
rtl/core/pcrt_pkg.sv
rtl/core/pcrt_in_if.sv
rtl/core/pcrt_out_if.sv
rtl/core/pcrt_coef_gen.sv
rtl/core/point_cloud_rigid_transform.sv
tb/pcrt_tb_if.sv
tb/point_cloud_rigid_transform_tb.sv
